// File: design/grid_min_start_health_dp_assert.svh
// Assertion macros for the grid minimum start health block.
`ifndef GRID_MIN_START_HEALTH_DP_ASSERT_SVH
`define GRID_MIN_START_HEALTH_DP_ASSERT_SVH

// Check a property on the rising clock, off while reset is held.
`define GMSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock, reset included.
`define GMSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/gmsh_pkg.sv
// Package for the grid minimum start health block: widths, limits, stage type.
package gmsh_pkg;

  localparam int CELL_W       = 16;
  localparam int NEED_W       = 31;
  localparam int CFG_W        = 11;
  localparam int MAX_COLS_DEF = 1024;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 32;

  localparam logic [NEED_W-1:0] NEED_MAX   = {NEED_W{1'b1}};
  localparam logic [NEED_W-1:0] NEED_ONE   = NEED_W'(1);
  localparam logic [CFG_W-1:0]  COLS_RESET = CFG_W'(1024);

  // Control word carried beside a cell from read to update.
  typedef struct packed {
    logic first_row;
    logic pos_zero;
    logic last;
  } cell_ctl_t;

endpackage

// File: design/grid_min_start_health_dp.sv
// Top level of the grid minimum start health block (dungeon game DP).
//
// Usage: stream the grid's signed cells on in_* in reverse raster order,
// bottom row first and each row right to left; in_tlast marks the top-left
// cell. cfg_we/cfg_wdata set the column count (0 counts as 1, values above
// MAX_COLS count as MAX_COLS); the user must write them only while the block
// is idle, which the block does not enforce. One result leaves on out_* per
// grid: out_tdata carries the minimum start health and a sticky saturation flag.
// Throughput: one cell per cycle, sustained while no finished grid waits on a
// stalled output. The last cell is registered in the row buffer read stage;
// min, subtract, clamp and write back then load the result and out_tvalid into
// the output register, which waits while the receiver stalls.
// Reset clears the grid position, saturation flag and the update stage and
// output valid flags, sets the first-row flag and loads a column count of
// 1024; the row buffer is not cleared, since every entry is written in the
// bottom row before it is read. When the receiver stalls, the held result
// does not block new cells; only a second finished grid waits, and then
// in_tready drops until the held request is taken.
module grid_min_start_health_dp #(
  parameter int MAX_COLS = gmsh_pkg::MAX_COLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [gmsh_pkg::CFG_W-1:0]         cfg_wdata,   // column_count
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gmsh_pkg::IN_DATA_W-1:0]     in_tdata,    // [15:0] cell_value
  input  logic                               in_tlast,    // last_cell
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gmsh_pkg::OUT_DATA_W-1:0]    out_tdata    // [30:0] initial_health,
                                                          // [31] overflow
);
  import gmsh_pkg::*;

  `include "grid_min_start_health_dp_assert.svh"

  localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CNT_W  = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
  localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLS);

  // Row buffer: need of each cell of the row below, by distance from right.
  logic [NEED_W-1:0] row_mem [MAX_COLS];

  logic [CFG_W-1:0]  col_count_r;
  logic [ADDR_W-1:0] col_pos_r, col_pos_nxt;
  logic              first_row_r, first_row_nxt;
  logic              ovf_seen_r, ovf_seen_nxt;
  logic [NEED_W-1:0] right_need_r;

  // Update stage registers.
  logic              s1_valid_r;
  cell_ctl_t         s1_ctl_r;
  logic [ADDR_W-1:0] s1_pos_r;
  logic [CELL_W-1:0] s1_cell_r;
  logic [NEED_W-1:0] rd_data_r;
  logic              fwd_hit_r;
  logic [NEED_W-1:0] fwd_data_r;

  logic              out_valid_r;
  logic [NEED_W-1:0] out_need_r;
  logic              out_ovf_r;

  logic              in_fire, s1_fire, out_free;
  logic [CNT_W-1:0]  cols_act, pos_inc;
  logic              row_end;

  logic [NEED_W-1:0] below, right, best, need_sat;
  logic signed [NEED_W+1:0] diff;
  logic              need_ovf;

  // ---------------------------------------------------------------- handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && (!s1_ctl_r.last || out_free);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // ------------------------------------------------------- position tracking
  always_comb begin
    if (col_count_r == '0) begin
      cols_act = CNT_W'(1);
    end else if (CNT_W'(col_count_r) > MAX_COLS_C) begin
      cols_act = MAX_COLS_C;
    end else begin
      cols_act = CNT_W'(col_count_r);
    end
    pos_inc = CNT_W'(col_pos_r) + CNT_W'(1);
    row_end = (pos_inc >= cols_act);
  end

  always_comb begin
    col_pos_nxt   = col_pos_r;
    first_row_nxt = first_row_r;
    if (in_fire) begin
      if (in_tlast) begin
        col_pos_nxt   = '0;
        first_row_nxt = 1'b1;
      end else if (row_end) begin
        col_pos_nxt   = '0;
        first_row_nxt = 1'b0;
      end else begin
        col_pos_nxt   = pos_inc[ADDR_W-1:0];
      end
    end
  end

  // ----------------------------------------------------------- need compute
  always_comb begin
    below = s1_ctl_r.first_row ? NEED_MAX : (fwd_hit_r ? fwd_data_r : rd_data_r);
    right = s1_ctl_r.pos_zero ? NEED_MAX : right_need_r;
    best  = (below < right) ? below : right;
    // Bottom-right cell: the walker only needs to end alive.
    if (s1_ctl_r.first_row && s1_ctl_r.pos_zero) begin
      best = NEED_ONE;
    end
    diff = $signed({2'b00, best}) - $signed({{(NEED_W+2-CELL_W){s1_cell_r[CELL_W-1]}}, s1_cell_r});
    need_ovf = 1'b0;
    if (diff < $signed((NEED_W+2)'(1))) begin
      need_sat = NEED_ONE;
    end else if (diff > $signed({2'b00, NEED_MAX})) begin
      need_sat = NEED_MAX;
      need_ovf = 1'b1;
    end else begin
      need_sat = diff[NEED_W-1:0];
    end
  end

  always_comb begin
    ovf_seen_nxt = ovf_seen_r;
    if (s1_fire) begin
      ovf_seen_nxt = s1_ctl_r.last ? 1'b0 : (ovf_seen_r || need_ovf);
    end
  end

  // ------------------------------------------------------------ row buffer
  // Write back on update; read on accept. A write to the entry being read in
  // the same cycle is forwarded, which covers a one-column grid.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      row_mem[s1_pos_r] <= need_sat;
    end
    if (in_fire) begin
      rd_data_r  <= row_mem[col_pos_r];
      fwd_data_r <= need_sat;
      fwd_hit_r  <= s1_fire && (s1_pos_r == col_pos_r);
      s1_pos_r   <= col_pos_r;
      s1_cell_r  <= in_tdata[CELL_W-1:0];
      s1_ctl_r   <= '{first_row: first_row_r, pos_zero: (col_pos_r == '0), last: in_tlast};
    end
    if (s1_fire) begin
      right_need_r <= need_sat;
    end
    if (s1_fire && s1_ctl_r.last) begin
      out_need_r <= need_sat;
      out_ovf_r  <= ovf_seen_r || need_ovf;
    end
  end

  // --------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= COLS_RESET;
      col_pos_r   <= '0;
      first_row_r <= 1'b1;
      ovf_seen_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        col_count_r <= cfg_wdata;
      end
      col_pos_r   <= col_pos_nxt;
      first_row_r <= first_row_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      // Load a finished grid, else drop the request once taken.
      if (s1_fire && s1_ctl_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ovf_r, out_need_r};

  // ------------------------------------------------------------ assertions
  `GMSH_ASSERT(a_stall_cause, !in_tready |-> (s1_valid_r && s1_ctl_r.last && out_valid_r), "in_tready low without a blocked finished grid")
  `GMSH_ASSERT(a_grid_restart, (in_fire && in_tlast) |=> (col_pos_r == '0 && first_row_r), "grid did not restart after last cell")
  `GMSH_ASSERT(a_result_loaded, (s1_fire && s1_ctl_r.last) |=> out_valid_r, "finished grid not presented")

endmodule
